>>> src/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> src/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// Types and constants of the second-moment sketch.
// ----------------------------------------------------------------------------
package ams_pkg;
    localparam int NUM_VARS = 16;
    localparam int SLOT_W   = 4;
    localparam int K_W      = 5;

    localparam logic [1:0] MODE_ELEMENT = 2'd0;
    localparam logic [1:0] MODE_LOAD    = 2'd1;
    localparam logic [1:0] MODE_REPORT  = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    localparam logic [1:0] REG_FINITE = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_VARS   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] element;
        logic [31:0] start_time;
        logic [15:0] accept_draw;
        logic [3:0]  slot_draw;
    } item_t;

    typedef struct packed {
        logic [3:0]  slot_number;
        logic        occupied;
        logic [63:0] sampled_element;
        logic [63:0] estimate;
        logic        saturated;
        logic        last;
    } result_t;

    // broadcast to every cell
    typedef struct packed {
        logic        upd;
        logic [63:0] element;
        logic        rep_load;
        logic        rep_shift;
    } cell_cmd_t;

    // snapshot handed down the chain during a report
    typedef struct packed {
        logic        valid;
        logic [63:0] element;
        logic [31:0] count;
    } rep_t;
endpackage

>>> src/ams_cell.sv
// ----------------------------------------------------------------------------
// ams_cell
// One estimator slot: element, count, valid, and one report chain stage.
// ----------------------------------------------------------------------------
module ams_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ams_pkg::cell_cmd_t cmd,
    input  logic               start_hit,
    input  ams_pkg::rep_t      rep_in,
    output ams_pkg::rep_t      rep_out
);
    logic          valid_reg;
    logic [63:0]   elem_reg;
    logic [31:0]   count_reg;
    ams_pkg::rep_t rep_reg;
    logic          match;

    assign match = valid_reg && (elem_reg == cmd.element) && (count_reg != 32'hFFFF_FFFF);

    // hold valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.upd && start_hit)
        begin
            valid_reg <= 1'b1;
        end
    end

    // restart or count the slot
    always_ff @(posedge clk)
    begin
        if (cmd.upd && start_hit)
        begin
            elem_reg  <= cmd.element;
            count_reg <= 32'd1;
        end
        else if (cmd.upd && match)
        begin
            count_reg <= count_reg + 32'd1;
        end
    end

    // capture or advance the report chain
    always_ff @(posedge clk)
    begin
        if (cmd.rep_load)
        begin
            rep_reg.valid   <= valid_reg;
            rep_reg.element <= elem_reg;
            rep_reg.count   <= count_reg;
        end
        else if (cmd.rep_shift)
        begin
            rep_reg <= rep_in;
        end
    end

    assign rep_out = rep_reg;
endmodule

>>> src/ams_estimate.sv
// ----------------------------------------------------------------------------
// ams_estimate
// Two-stage pipeline forming n*(2c-1) with saturation for one slot a beat.
// ----------------------------------------------------------------------------
module ams_estimate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  ams_pkg::rep_t    rep,
    input  logic [3:0]       slot,
    input  logic             last,
    input  logic [31:0]      n,
    output logic             strobe,
    output ams_pkg::result_t result
);
    logic        s1_valid_reg;
    logic [3:0]  s1_slot_reg;
    logic        s1_occ_reg;
    logic        s1_nz_reg;
    logic        s1_last_reg;
    logic [63:0] s1_elem_reg;
    logic [31:0] s1_n_reg;
    logic [32:0] s1_m_reg;
    logic [64:0] prod;
    logic        out_valid_reg;
    ams_pkg::result_t out_reg;

    assign prod = {33'd0, s1_n_reg} * {32'd0, s1_m_reg};

    // track beats through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= take;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // stage 1: form 2c-1
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_slot_reg <= slot;
            s1_occ_reg  <= rep.valid;
            s1_nz_reg   <= rep.count != 32'd0;
            s1_last_reg <= last;
            s1_elem_reg <= rep.valid ? rep.element : 64'd0;
            s1_n_reg    <= n;
            s1_m_reg    <= {rep.count, 1'b0} - 33'd1;
        end
    end

    // stage 2: multiply and saturate
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            out_reg.slot_number     <= s1_slot_reg;
            out_reg.occupied        <= s1_occ_reg;
            out_reg.sampled_element <= s1_elem_reg;
            out_reg.last            <= s1_last_reg;
            if (s1_occ_reg && s1_nz_reg)
            begin
                out_reg.saturated <= prod[64];
                out_reg.estimate  <= prod[64] ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
            end
            else
            begin
                out_reg.saturated <= 1'b0;
                out_reg.estimate  <= 64'd0;
            end
        end
    end

    assign strobe = out_valid_reg;
    assign result = out_reg;
endmodule

>>> src/ams_second_moment_sketch.sv
// ----------------------------------------------------------------------------
// ams_second_moment_sketch
// AMS second-moment estimator built as a row of slot cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. A reservoir-mode element
// and a start-time load do not raise busy. A finite-mode element holds busy
// in the skip state while it consumes start times (at most 16), one table
// entry checked per cycle, and the next item is taken once it is back in
// idle. A report holds busy while the snapshot shifts one slot a cycle down
// the cell row; its k results follow on strobe, one per cycle, through the
// stage-1 and output registers of the estimate multiplier. The receiver
// cannot stall: each result is on the ports for one cycle only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ams_second_moment_sketch (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ams_pkg::item_t    item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              strobe,
    output ams_pkg::result_t  result
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SKIP   = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        finite_reg;
    logic [31:0] length_reg;
    logic [4:0]  vars_reg;
    logic [31:0] time_reg;
    logic [4:0]  ptr_reg;
    logic [4:0]  load_reg;
    logic [4:0]  fill_reg;
    logic        hit_reg;
    logic [63:0] hold_reg;
    logic [3:0]  idx_reg;
    logic [31:0] table_reg [ams_pkg::NUM_VARS];

    logic [4:0]  k_eff;
    logic        accept;
    logic        scan;
    logic        skip_done;
    logic        res_ok;
    logic [47:0] draw_prod;
    logic [ams_pkg::NUM_VARS-1:0] start_vec;
    ams_pkg::cell_cmd_t cmd;
    ams_pkg::rep_t      chain [ams_pkg::NUM_VARS+1];
    logic        take;
    logic        rep_last;

    assign cfg_ready = 1'b1;
    assign busy      = state_reg != S_IDLE;
    assign accept    = start && !busy;

    // clamp k to 1..16
    always_comb
    begin
        if (vars_reg == 5'd0)
            k_eff = 5'd1;
        else if (vars_reg > 5'(ams_pkg::NUM_VARS))
            k_eff = 5'(ams_pkg::NUM_VARS);
        else
            k_eff = vars_reg;
    end

    // reservoir acceptance test
    assign draw_prod = {32'd0, item.accept_draw} * {16'd0, time_reg};
    assign res_ok    = (draw_prod <= {27'd0, k_eff, 16'd0})
                       && ({1'b0, item.slot_draw} < k_eff);

    // start table scan
    assign scan      = (ptr_reg < load_reg) && !ptr_reg[4]
                       && (table_reg[ptr_reg[3:0]] <= time_reg);
    assign skip_done = (state_reg == S_SKIP) && !scan;

    assign rep_last  = ({1'b0, idx_reg} + 5'd1) == k_eff;
    assign take      = state_reg == S_REPORT;

    // drive cell commands
    always_comb
    begin
        cmd.upd       = 1'b0;
        cmd.element   = item.element;
        cmd.rep_load  = accept && (item.mode == ams_pkg::MODE_REPORT);
        cmd.rep_shift = take;
        start_vec     = '0;
        if (skip_done)
        begin
            cmd.upd     = 1'b1;
            cmd.element = hold_reg;
            if (hit_reg && (fill_reg < k_eff))
                start_vec[fill_reg[3:0]] = 1'b1;
        end
        else if (accept && (item.mode == ams_pkg::MODE_ELEMENT) && !finite_reg)
        begin
            cmd.upd = 1'b1;
            if (time_reg < {27'd0, k_eff})
                start_vec[time_reg[3:0]] = 1'b1;
            else if (res_ok)
                start_vec[item.slot_draw] = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.mode == ams_pkg::MODE_ELEMENT) && finite_reg)
                    state_next = S_SKIP;
                else if (accept && (item.mode == ams_pkg::MODE_REPORT))
                    state_next = S_REPORT;
            end
            S_SKIP:
            begin
                if (!scan)
                    state_next = S_IDLE;
            end
            S_REPORT:
            begin
                if (rep_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            finite_reg <= 1'b0;
            length_reg <= 32'd0;
            vars_reg   <= 5'd16;
            time_reg   <= 32'd0;
            ptr_reg    <= 5'd0;
            load_reg   <= 5'd0;
            fill_reg   <= 5'd0;
            hit_reg    <= 1'b0;
            idx_reg    <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ams_pkg::REG_FINITE: finite_reg <= cfg_data[0];
                    ams_pkg::REG_LENGTH: length_reg <= cfg_data;
                    ams_pkg::REG_VARS:   vars_reg   <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (accept && (item.mode == ams_pkg::MODE_LOAD) && !load_reg[4])
                load_reg <= load_reg + 5'd1;
            if (accept && (item.mode == ams_pkg::MODE_ELEMENT))
            begin
                hit_reg <= 1'b0;
                if (!finite_reg)
                    time_reg <= time_reg + 32'd1;
            end
            if ((state_reg == S_SKIP) && scan)
            begin
                ptr_reg <= ptr_reg + 5'd1;
                if (table_reg[ptr_reg[3:0]] == time_reg)
                    hit_reg <= 1'b1;
            end
            if (skip_done)
            begin
                time_reg <= time_reg + 32'd1;
                if (hit_reg && (fill_reg < k_eff))
                    fill_reg <= fill_reg + 5'd1;
            end
            if (accept && (item.mode == ams_pkg::MODE_REPORT))
                idx_reg <= 4'd0;
            else if (take)
                idx_reg <= idx_reg + 4'd1;
        end
    end

    // hold element and start table
    always_ff @(posedge clk)
    begin
        if (accept && (item.mode == ams_pkg::MODE_ELEMENT))
            hold_reg <= item.element;
        if (accept && (item.mode == ams_pkg::MODE_LOAD) && !load_reg[4])
            table_reg[load_reg[3:0]] <= item.start_time;
    end

    // row of slot cells
    assign chain[ams_pkg::NUM_VARS] = '0;
    for (genvar g = 0; g < ams_pkg::NUM_VARS; g++)
    begin : g_cell
        ams_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .start_hit (start_vec[g]),
            .rep_in    (chain[g+1]),
            .rep_out   (chain[g])
        );
    end

    ams_estimate u_est (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .rep    (chain[0]),
        .slot   (idx_reg),
        .last   (rep_last),
        .n      (length_reg),
        .strobe (strobe),
        .result (result)
    );

    `ASSERT_IMPL(a_sat_ones, clk, rst_n, strobe && result.saturated,
                 result.estimate == 64'hFFFF_FFFF_FFFF_FFFF)
    `ASSERT_IMPL(a_empty_zero, clk, rst_n, strobe && !result.occupied,
                 result.estimate == 64'd0 && result.sampled_element == 64'd0)
    `ASSERT_IMPL(a_ptr_bound, clk, rst_n, state_reg == S_SKIP, ptr_reg <= load_reg)
    `ASSERT_NEXT(a_report_out, clk, rst_n, take, ##1 strobe)
endmodule
